/* rtl/core/sprite_frame_sequencer_core_macros.svh */
// Assertion helpers for the frame sequencer core.
// Every check is clocked on i_clk and held off while i_rst_n is low.
`ifndef SPRITE_FRAME_SEQUENCER_CORE_MACROS_SVH
`define SPRITE_FRAME_SEQUENCER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sfs check failed");

// Consequent must hold in the cycle after the antecedent.
`define SFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sfs check failed");

`endif

/* rtl/core/sfs_pkg.sv */
package sfs_pkg;

    localparam int unsigned FrameW   = 8;
    localparam int unsigned TimeW    = 32;
    localparam int unsigned PeriodW  = 16;
    localparam int unsigned EndW     = 9;
    localparam int unsigned ColsW    = 9;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned DivCntW  = 6;

    // Sequence wraps modulo MaxFrames, i.e. the frame counter is FrameW bits.
    localparam int unsigned MaxFrames = 1 << FrameW;

    localparam logic [DivCntW-1:0] TimeSteps = DivCntW'(TimeW);
    localparam logic [DivCntW-1:0] TileSteps = DivCntW'(FrameW);

    localparam logic [PeriodW-1:0] PeriodReset = 16'd66;
    localparam logic [EndW-1:0]    EndReset    = 9'd255;
    localparam logic [ColsW-1:0]   ColsReset   = 9'd1;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_FRAME_PERIOD  = 3'd0,
        CFG_LOOPING       = 3'd1,
        CFG_PAUSED        = 3'd2,
        CFG_START_FRAME   = 3'd3,
        CFG_END_FRAME     = 3'd4,
        CFG_SHEET_COLUMNS = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_TIME_DIV,
        ST_TARGET,
        ST_TILE,
        ST_TILE_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [TimeW-1:0]     dividend;
        logic [PeriodW-1:0]   divisor;
        logic [DivCntW-1:0]   steps;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [TimeW-1:0]     quotient;
        logic [PeriodW-1:0]   remainder;
    } t_div_rsp;

endpackage

/* rtl/core/sfs_div.sv */
// Restoring divider, one quotient bit per cycle. The dividend is consumed
// from its MSB, so a short division loads its operand left-aligned.
module sfs_div
    import sfs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                r_busy;
    logic                r_done;
    logic [DivCntW-1:0]  r_cnt;
    logic [TimeW-1:0]    r_dvd;
    logic [TimeW-1:0]    r_quo;
    logic [PeriodW-1:0]  r_rem;
    logic [PeriodW-1:0]  r_dsr;

    logic [PeriodW:0]    w_shift;
    logic                w_ge;
    logic [PeriodW:0]    w_diff;

    assign w_shift = {r_rem, r_dvd[TimeW-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dsr});
    assign w_diff  = w_shift - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DivCntW'(1);
                if (r_cnt == DivCntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dsr <= i_req.divisor;
            r_quo <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[TimeW-2:0], 1'b0};
            r_quo <= {r_quo[TimeW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[PeriodW-1:0] : w_shift[PeriodW-1:0];
        end
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

/* rtl/core/sprite_frame_sequencer_core.sv */
// Sprite sheet frame sequencer.
// Input channel (i_valid / o_ready): one item per transfer. i_kind = 0 is a
// time tick carrying i_elapsed time units, i_kind = 1 restarts the sequence
// at the start frame. Every item gives exactly one result on the output
// channel (o_valid / i_ready): frame index, sheet column and row, and a flag
// telling whether the item set the frame.
// Flow: one item at a time; o_ready is high only while the sequencer is
// idle. An advancing tick passes ST_CHECK, ST_TIME_DIV (the shared serial
// divider divides elapsed time by the frame period), ST_TARGET, ST_TILE,
// ST_TILE_DIV (frame over sheet columns) and ST_OUT, which loads its
// result; the next input transfer comes after that load. Paused ticks,
// restarts and ticks below one period skip the time division.
// The result sits in an output register; a stalled receiver holds it there,
// and a new item may be taken meanwhile, but its result waits until the
// register is free.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx;
// write only while the block is idle. Unknown indexes are dropped.
// Reset (synchronous, i_rst_n low): registers return to their defaults
// (period 66, end frame 255, one column), frame and time remainder clear.
`include "sprite_frame_sequencer_core_macros.svh"

module sprite_frame_sequencer_core
    import sfs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic [CfgIdxW-1:0]   i_cfg_idx,
    input  logic [CfgDataW-1:0]  i_cfg_data,

    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_kind,
    input  logic [PeriodW-1:0]   i_elapsed,

    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [FrameW-1:0]    o_frame_index,
    output logic [FrameW-1:0]    o_tile_column,
    output logic [FrameW-1:0]    o_tile_row,
    output logic                 o_advanced
);

    // Configuration registers
    logic [PeriodW-1:0]  r_period;
    logic                r_looping;
    logic                r_paused;
    logic [FrameW-1:0]   r_start;
    logic [EndW-1:0]     r_end;
    logic [ColsW-1:0]    r_cols;

    // Sequencer state and working registers
    t_state              r_state, n_state;
    logic [TimeW-1:0]    r_tr, n_tr;
    logic [FrameW-1:0]   r_frame, n_frame;
    logic [TimeW-1:0]    r_steps, n_steps;
    logic                r_adv, n_adv;
    logic [FrameW-1:0]   r_col, n_col;
    logic [FrameW-1:0]   r_row, n_row;

    // Output register
    logic                r_o_valid;
    logic [FrameW-1:0]   r_o_frame;
    logic [FrameW-1:0]   r_o_col;
    logic [FrameW-1:0]   r_o_row;
    logic                r_o_adv;

    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;

    logic                w_in_xfer;
    logic                w_out_load;
    logic [PeriodW-1:0]  w_period_eff;
    logic [ColsW-1:0]    w_cols_eff;
    logic                w_tr_lt_period;
    logic [TimeW-1:0]    w_target;
    logic                w_target_hit;
    logic [EndW-1:0]     w_end_m1;

    // ---------------------------------------------------------------
    // Configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= PeriodReset;
            r_looping <= 1'b0;
            r_paused  <= 1'b0;
            r_start   <= '0;
            r_end     <= EndReset;
            r_cols    <= ColsReset;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_PERIOD:  r_period  <= i_cfg_data[PeriodW-1:0];
                CFG_LOOPING:       r_looping <= i_cfg_data[0];
                CFG_PAUSED:        r_paused  <= i_cfg_data[0];
                CFG_START_FRAME:   r_start   <= i_cfg_data[FrameW-1:0];
                CFG_END_FRAME:     r_end     <= i_cfg_data[EndW-1:0];
                CFG_SHEET_COLUMNS: r_cols    <= i_cfg_data[ColsW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Shared arithmetic
    // ---------------------------------------------------------------
    // A zero period or zero column count behaves as one.
    assign w_period_eff   = (r_period == '0) ? PeriodW'(1) : r_period;
    assign w_cols_eff     = (r_cols == '0) ? ColsW'(1) : r_cols;
    assign w_tr_lt_period = (r_tr < TimeW'(w_period_eff));

    // Target wraps at the full time width before the end compare.
    assign w_target     = TimeW'(r_frame) + r_steps;
    assign w_target_hit = (w_target >= TimeW'(r_end));
    assign w_end_m1     = r_end - EndW'(1);

    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_load = (r_state == ST_OUT) && (!r_o_valid || i_ready);
    assign o_ready    = (r_state == ST_IDLE);

    sfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    if (i_kind || r_paused) begin
                        n_state = ST_TILE;
                    end else begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK:    n_state = w_tr_lt_period ? ST_TILE : ST_TIME_DIV;
            ST_TIME_DIV: if (w_div_rsp.done) n_state = ST_TARGET;
            ST_TARGET:   n_state = ST_TILE;
            ST_TILE:     n_state = ST_TILE_DIV;
            ST_TILE_DIV: if (w_div_rsp.done) n_state = ST_OUT;
            ST_OUT:      if (w_out_load) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: datapath controls
    // ---------------------------------------------------------------
    always_comb begin
        n_tr      = r_tr;
        n_frame   = r_frame;
        n_steps   = r_steps;
        n_adv     = r_adv;
        n_col     = r_col;
        n_row     = r_row;
        w_div_req = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    if (i_kind) begin
                        // restart keeps the time remainder
                        n_frame = r_start;
                        n_adv   = 1'b1;
                    end else begin
                        n_adv = 1'b0;
                        if (!r_paused) begin
                            n_tr = r_tr + TimeW'(i_elapsed);
                        end
                    end
                end
            end
            ST_CHECK: begin
                if (!w_tr_lt_period) begin
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = r_tr;
                    w_div_req.divisor  = w_period_eff;
                    w_div_req.steps    = TimeSteps;
                end
            end
            ST_TIME_DIV: begin
                if (w_div_rsp.done) begin
                    n_tr    = TimeW'(w_div_rsp.remainder);
                    n_steps = w_div_rsp.quotient;
                end
            end
            ST_TARGET: begin
                if (w_target_hit) begin
                    n_frame = r_looping ? r_start : w_end_m1[FrameW-1:0];
                end else begin
                    n_frame = w_target[FrameW-1:0];
                end
                n_adv = 1'b1;
            end
            ST_TILE: begin
                // left-align the frame so eight steps give the whole quotient
                w_div_req.start    = 1'b1;
                w_div_req.dividend = {r_frame, {(TimeW-FrameW){1'b0}}};
                w_div_req.divisor  = PeriodW'(w_cols_eff);
                w_div_req.steps    = TileSteps;
            end
            ST_TILE_DIV: begin
                if (w_div_rsp.done) begin
                    n_col = w_div_rsp.remainder[FrameW-1:0];
                    n_row = w_div_rsp.quotient[FrameW-1:0];
                end
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_tr    <= '0;
            r_frame <= '0;
        end else begin
            r_state <= n_state;
            r_tr    <= n_tr;
            r_frame <= n_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        r_steps <= n_steps;
        r_adv   <= n_adv;
        r_col   <= n_col;
        r_row   <= n_row;
    end

    // ---------------------------------------------------------------
    // Output register: load when free or being drained, else hold
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_frame <= r_frame;
            r_o_col   <= r_col;
            r_o_row   <= r_row;
            r_o_adv   <= r_adv;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_frame_index = r_o_frame;
    assign o_tile_column = r_o_col;
    assign o_tile_row    = r_o_row;
    assign o_advanced    = r_o_adv;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // Remainder left by the time division is below the period.
    `SFS_ASSERT_NOW(a_rem_below_period, r_state == ST_TARGET,
        r_tr < TimeW'(w_period_eff))
    // Divider is free whenever a new item may arrive.
    `SFS_ASSERT_NOW(a_div_idle, r_state == ST_IDLE, !w_div_rsp.busy)
    // Column and row rebuild the frame index.
    `SFS_ASSERT_NOW(a_tile_consistent, r_o_valid,
        (17'(r_o_row) * 17'(w_cols_eff) + 17'(r_o_col)) == 17'(r_o_frame))
    // A paused tick touches neither time nor frame.
    `SFS_ASSERT_NEXT(a_paused_tick, w_in_xfer && !i_kind && r_paused,
        $stable(r_tr) && $stable(r_frame))

endmodule
